// ----- rtl/core/lru_slot_manager_with_locks_top_macros.svh -----
// assertion macros for the lru slot manager top level
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef LRU_SLOT_MANAGER_WITH_LOCKS_TOP_MACROS_SVH
`define LRU_SLOT_MANAGER_WITH_LOCKS_TOP_MACROS_SVH

// same-cycle implication
`define LSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lsm_pkg.sv -----
// shared types and constants for the lru slot manager
// no dependencies
package lsm_pkg;

  localparam int ENTRIES   = 64;
  localparam int SLOT_W    = $clog2(ENTRIES);
  localparam int COUNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int SLOT_IO_W = 6;

  // command codes
  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [SLOT_IO_W-1:0] slot_in;
    logic [KEY_W-1:0]     key;
    logic                 lock;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_IO_W-1:0] slot_out;
    logic                 evicted;
    logic [KEY_W-1:0]     evicted_key;
    logic                 forced;
    logic                 ignored;
  } result_t;

  // contents of one recency cell
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic              lock;
  } cell_t;

endpackage

// ----- rtl/core/lsm_cell.sv -----
// one position of the recency stack: slot id, key, lock and valid
// depends on lsm_pkg
module lsm_cell import lsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_t             upper,
  input  logic              shift_en,
  input  logic [SLOT_W-1:0] cmp_slot,
  output cell_t             own,
  output logic              slot_hit,
  output logic              free_cand
);

  logic              valid;
  logic              lock;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  key;

  // control bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lock  <= 1'b0;
    end else if (shift_en) begin
      valid <= upper.valid;
      lock  <= upper.lock;
    end
  end

  // payload, taken from the newer neighbor on a shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      slot <= upper.slot;
      key  <= upper.key;
    end
  end

  assign own       = '{valid: valid, slot: slot, key: key, lock: lock};
  assign slot_hit  = valid && (slot == cmp_slot);
  assign free_cand = valid && !lock;

endmodule

// ----- rtl/core/lru_slot_manager_with_locks_top.sv -----
// top level of the lru slot manager with locked entries
// depends on lsm_pkg, lsm_cell and lru_slot_manager_with_locks_top_macros.svh
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   func selects touch (make slot_in most recent) or allocate (store key and
//   lock in a free slot, or evict an entry once all slots are filled).
//   The result is shown on result for exactly one cycle with done high; the
//   receiver cannot stall it and must take it in that cycle.
//   Recency lives in a row of cells, newest at cell 0 and oldest at the end.
//   Each command has a compare step, which checks every cell against the
//   command (slot match or oldest unlocked victim), and a shift step, which
//   moves the cells above the chosen one down by a place and loads the top
//   cell. busy is high during both steps; done rises in the cycle after
//   the shift, in which a new command may already be transferred, so a new
//   command is taken only once the previous one is done. The compare and
//   shift steps over the cell row do not depend on how many locked entries
//   are skipped; reset empties the row and the fill count, no clearing pass.
module lru_slot_manager_with_locks_top import lsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  `include "lru_slot_manager_with_locks_top_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  localparam logic [ENTRIES-1:0] LAST_ONEHOT = {1'b1, {(ENTRIES-1){1'b0}}};

  logic [1:0]         state;
  cmd_t               cmd_q;
  logic [COUNT_W-1:0] filled_count;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] hit_next;
  logic               ign;
  logic               evict;
  logic               forc;
  logic               grow;

  cell_t              cells [ENTRIES];
  cell_t              new_top;
  logic [ENTRIES-1:0] slot_hit;
  logic [ENTRIES-1:0] free_cand;
  logic [ENTRIES-1:0] cand;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] touch_hit;
  logic [ENTRIES-1:0] shift_en;
  logic [ENTRIES-1:0] valid_vec;
  logic [SLOT_W-1:0]  cmp_slot;
  logic               in_range;
  logic               full;
  logic               any_cand;
  cell_t              sel;

  assign busy     = (state != ST_IDLE);
  assign cmp_slot = SLOT_W'(cmd_q.slot_in);
  assign in_range = 32'(cmd_q.slot_in) < ENTRIES;
  assign full     = (filled_count == COUNT_W'(ENTRIES));

  // row of recency cells, each fed by its newer neighbor
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam logic [ENTRIES-1:0] AT_OR_OLDER = {ENTRIES{1'b1}} << i;
    localparam logic [ENTRIES-1:0] OLDER       = {ENTRIES{1'b1}} << (i + 1);

    lsm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .upper     ((i == 0) ? new_top : cells[(i == 0) ? 0 : i - 1]),
      .shift_en  (shift_en[i]),
      .cmp_slot  (cmp_slot),
      .own       (cells[i]),
      .slot_hit  (slot_hit[i]),
      .free_cand (free_cand[i])
    );

    // the newest entry is never a normal victim
    assign cand[i]      = (i != 0) && free_cand[i];
    // oldest unlocked entry: no unlocked entry further down the row
    assign victim[i]    = cand[i] && !(|(cand & OLDER));
    assign touch_hit[i] = slot_hit[i] && in_range;
    assign shift_en[i]  = (state == ST_APPLY) && (|(hit & AT_OR_OLDER));
    assign valid_vec[i] = cells[i].valid;
  end

  assign any_cand = |cand;

  // choose the cell that moves to the top
  always_comb begin
    if (cmd_q.func == FUNC_TOUCH) begin
      hit_next = touch_hit;
    end else if (!full || !any_cand) begin
      hit_next = LAST_ONEHOT;
    end else begin
      hit_next = victim;
    end
  end

  // read out the chosen cell, one-hot and-or over the row
  always_comb begin
    sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel = sel | (hit[i] ? cells[i] : '0);
    end
  end

  // contents loaded into the newest cell
  always_comb begin
    new_top       = sel;
    new_top.valid = 1'b1;
    if (cmd_q.func == FUNC_ALLOC) begin
      new_top.key  = cmd_q.key;
      new_top.lock = cmd_q.lock;
      if (grow) begin
        new_top.slot = SLOT_W'(filled_count);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      filled_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == ST_APPLY);
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          state <= ST_IDLE;
          if (grow) begin
            filled_count <= filled_count + COUNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // command capture, match results and result register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_q <= cmd;
    end
    if (state == ST_MATCH) begin
      hit   <= hit_next;
      ign   <= (cmd_q.func == FUNC_TOUCH) && !(|touch_hit);
      evict <= (cmd_q.func == FUNC_ALLOC) && full;
      forc  <= (cmd_q.func == FUNC_ALLOC) && full && !any_cand;
      grow  <= (cmd_q.func == FUNC_ALLOC) && !full;
    end
    if (state == ST_APPLY) begin
      result.slot_out    <= (cmd_q.func == FUNC_TOUCH) ? cmd_q.slot_in
                                                       : SLOT_IO_W'(new_top.slot);
      result.evicted     <= evict;
      result.evicted_key <= evict ? sel.key : '0;
      result.forced      <= forc;
      result.ignored     <= ign;
    end
  end

  // checks
  `LSM_ASSERT_NOW(a_hit_onehot, state == ST_APPLY, $onehot0(hit),
                  "more than one cell chosen")
  `LSM_ASSERT_NEXT(a_done_after_apply, state == ST_APPLY, done && !busy,
                   "result not shown after the shift cycle")
  `LSM_ASSERT_NOW(a_valid_count, state == ST_IDLE,
                  32'($countones(valid_vec)) == 32'(filled_count),
                  "valid cells disagree with fill count")
  `LSM_ASSERT_NOW(a_evict_full, done && result.evicted,
                  filled_count == COUNT_W'(ENTRIES),
                  "eviction before all slots filled")

endmodule
